@@ rtl/dtlf_pkg.sv @@
// Shared constants, types and helpers of the decision tree leaf finder.
package dtlf_pkg;

   // Sizes of the stores
   localparam int NODE_COUNT    = 1024;
   localparam int FEATURE_COUNT = 256;
   localparam int VALUE_WIDTH   = 16;

   // Address widths (at least one bit)
   localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

   // Fixed field widths of the ports
   localparam int FNUM_W  = 8;
   localparam int CHILD_W = 10;
   localparam int IN_VAL_W = 16;
   localparam int LEAF_W  = 11;

   // One entry of the node memory
   typedef struct packed {
      logic [FNUM_W-1:0]      feature;
      logic [VALUE_WIDTH-1:0] threshold;
      logic [CHILD_W-1:0]     child;
   } node_entry_type;

   // Read addresses from the walker to the memories
   typedef struct packed {
      logic [NODE_AW-1:0] node_addr;
      logic [FEAT_AW-1:0] feat_addr;
   } mem_rd_type;

   // Result word of a walk
   typedef struct packed {
      logic              valid;
      logic [LEAF_W-1:0] leaf_number;
      logic              walk_error;
   } rsp_type;

   // Sign-extend (or truncate) a 16-bit port value to the stored width
   function automatic logic [VALUE_WIDTH-1:0] to_value(input logic signed [IN_VAL_W-1:0] v);
      logic signed [VALUE_WIDTH-1:0] r;
      r = VALUE_WIDTH'(v);
      return r;
   endfunction

endpackage

@@ rtl/decision_tree_leaf_finder.sv @@
// Top level of the decision tree leaf finder: word decode, memories and walker.
//
//  channel   handshake         fields
//  -------   ---------------   ------------------------------------------------
//  request   start / busy      req_opcode, req_node_index, req_node_feature,
//                              req_node_threshold, req_node_child,
//                              req_feature_index, req_feature_value,
//                              req_last_feature
//  response  rsp_valid strobe  rsp_leaf_number, rsp_walk_error
//
// Node and feature words are written in the cycle they are taken, one per cycle
// while busy is low. A word with last_feature set starts a walk; each tree level
// is a node memory read, then a feature memory read. Busy stays high until a
// leaf is found or the walk fails; the result strobe rises with its fall. An
// overrun gives up after NODE_COUNT levels. The strobe is high for one cycle
// and cannot be held off. Reset clears only the control state; memory contents
// are undefined until written.
module decision_tree_leaf_finder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [9:0]           req_node_index,
   input  logic [7:0]           req_node_feature,
   input  logic signed [15:0]   req_node_threshold,
   input  logic [9:0]           req_node_child,
   input  logic [7:0]           req_feature_index,
   input  logic signed [15:0]   req_feature_value,
   input  logic                 req_last_feature,
   output logic                 rsp_valid,
   output logic [10:0]          rsp_leaf_number,
   output logic                 rsp_walk_error
);
   import dtlf_pkg::*;

   localparam logic OP_NODE = 1'b0;
   localparam logic OP_FEAT = 1'b1;

   logic                   take;
   logic                   node_we, feat_we;
   node_entry_type         node_wdata, node_rdata;
   logic [VALUE_WIDTH-1:0] feat_wdata, feat_rdata;
   logic                   start_walk;
   mem_rd_type             rd;
   rsp_type                rsp;

   // word decode
   always_comb begin
      take       = start && !busy;
      node_we    = take && (req_opcode == OP_NODE) && (32'(req_node_index) < NODE_COUNT);
      feat_we    = take && (req_opcode == OP_FEAT)
                   && (32'(req_feature_index) < FEATURE_COUNT);
      start_walk = take && (req_opcode == OP_FEAT) && req_last_feature;
      node_wdata.feature   = req_node_feature;
      node_wdata.threshold = to_value(req_node_threshold);
      node_wdata.child     = req_node_child;
      feat_wdata           = to_value(req_feature_value);
   end

   // node table
   dtlf_ram #(
      .WIDTH ($bits(node_entry_type)),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (NODE_AW'(req_node_index)),
      .wr_data (node_wdata),
      .rd_addr (rd.node_addr),
      .rd_data (node_rdata)
   );

   // sample feature store
   dtlf_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (FEATURE_COUNT)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_we),
      .wr_addr (FEAT_AW'(req_feature_index)),
      .wr_data (feat_wdata),
      .rd_addr (rd.feat_addr),
      .rd_data (feat_rdata)
   );

   // walk sequencer
   dtlf_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .start_walk (start_walk),
      .node_rdata (node_rdata),
      .feat_rdata (feat_rdata),
      .rd         (rd),
      .busy       (busy),
      .rsp        (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_leaf_number = rsp.leaf_number;
   assign rsp_walk_error  = rsp.walk_error;

endmodule

@@ rtl/dtlf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module dtlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dtlf_walk.sv @@
// Tree walk sequencer: alternates node and feature memory reads until a leaf or a walk error.
module dtlf_walk (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_walk,
   input  dtlf_pkg::node_entry_type  node_rdata,
   input  logic [dtlf_pkg::VALUE_WIDTH-1:0] feat_rdata,
   output dtlf_pkg::mem_rd_type      rd,
   output logic                      busy,
   output dtlf_pkg::rsp_type         rsp
);
   import dtlf_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_NODE, S_FEAT} state_type;

   localparam logic [NODE_AW-1:0] VIS_MAX = NODE_AW'(NODE_COUNT - 1);

   state_type              state_ff, state_in;
   logic [NODE_AW-1:0]     node_ff, node_in;
   logic [NODE_AW-1:0]     visits_ff, visits_in;
   logic [VALUE_WIDTH-1:0] thr_ff, thr_in;
   logic [CHILD_W-1:0]     child_ff, child_in;
   logic                   finr_ff, finr_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0] value;
   logic                   go_left;
   logic [CHILD_W-1:0]     next_idx;
   logic                   next_ok;

   // compare stage: feature word against the held threshold
   always_comb begin
      value    = finr_ff ? feat_rdata : '0;
      go_left  = $signed(value) < $signed(thr_ff);
      next_idx = go_left ? (child_ff - CHILD_W'(1)) : child_ff;
      next_ok  = 32'(next_idx) < NODE_COUNT;
   end

   // memory read addresses
   always_comb begin
      rd.node_addr = (state_ff == S_FEAT) ? NODE_AW'(next_idx) : '0;
      rd.feat_addr = FEAT_AW'(node_rdata.feature);
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      node_in   = node_ff;
      visits_in = visits_ff;
      thr_in    = thr_ff;
      child_in  = child_ff;
      finr_in   = finr_ff;
      rsp_in    = rsp_ff;
      rsp_in.valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start_walk) begin
               state_in  = S_NODE;
               node_in   = '0;
               visits_in = '0;
            end
         end
         S_NODE: begin
            if (node_rdata.child == '0) begin
               // leaf reached
               rsp_in.valid       = 1'b1;
               rsp_in.leaf_number = LEAF_W'(32'(node_ff) + 1);
               rsp_in.walk_error  = 1'b0;
               state_in           = S_IDLE;
            end else begin
               thr_in   = node_rdata.threshold;
               child_in = node_rdata.child;
               finr_in  = 32'(node_rdata.feature) < FEATURE_COUNT;
               state_in = S_FEAT;
            end
         end
         S_FEAT: begin
            if (!next_ok || visits_ff == VIS_MAX) begin
               // child out of range or overrun
               rsp_in.valid       = 1'b1;
               rsp_in.leaf_number = '0;
               rsp_in.walk_error  = 1'b1;
               state_in           = S_IDLE;
            end else begin
               node_in   = NODE_AW'(next_idx);
               visits_in = visits_ff + NODE_AW'(1);
               state_in  = S_NODE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      node_ff            <= node_in;
      visits_ff          <= visits_in;
      thr_ff             <= thr_in;
      child_ff           <= child_in;
      finr_ff            <= finr_in;
      rsp_ff.leaf_number <= rsp_in.leaf_number;
      rsp_ff.walk_error  <= rsp_in.walk_error;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp  = rsp_ff;

endmodule
